// File: rtl/utf8_to_latin1_stream_core_assert.svh
// Assertion macros for the UTF-8 to Latin-1 stream core.
// Expect clk and arst_n in the scope of the use.
`ifndef UTF8_TO_LATIN1_STREAM_CORE_ASSERT_SVH
`define UTF8_TO_LATIN1_STREAM_CORE_ASSERT_SVH

// Condition must hold at every edge out of reset.
`define U2L_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("u2l invariant violated");

// Consequent must hold in the cycle after the antecedent.
`define U2L_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("u2l sequence check failed");

`endif

// File: rtl/u2l_pkg.sv
// Package for the UTF-8 to Latin-1 stream core: beat types, byte codes
// and the single-byte decode function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package u2l_pkg;

	localparam logic [7:0] REPL_RESET = 8'h3F;
	localparam logic [7:0] LEAD_C2    = 8'hC2;
	localparam logic [7:0] LEAD_C3    = 8'hC3;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_final;
		logic       string_end;
	} out_beat_t;

	// Outcome of decoding one byte with no lead pending and no skip active
	typedef struct packed {
		logic       emit;
		logic [7:0] data;
		logic       lead;
		logic       c3;
		logic [1:0] skip;
	} dec_t;

	function automatic logic is_cont(input logic [7:0] b);
		return b[7:6] == 2'b10;
	endfunction

	function automatic dec_t decode(input logic [7:0] b, input logic last,
		input logic [7:0] repl);
		dec_t d;
		d.emit = 1'b1;
		d.data = repl;
		d.lead = 1'b0;
		d.c3   = (b == LEAD_C3);
		d.skip = 2'd0;
		if (!b[7]) begin
			d.data = b;
		end else if (b == LEAD_C2 || b == LEAD_C3) begin
			// a lead on the last byte cannot complete
			if (!last) begin
				d.emit = 1'b0;
				d.lead = 1'b1;
			end
		end else if (b[7:5] == 3'b110) begin
			d.skip = 2'd1;
		end else if (b[7:4] == 4'b1110) begin
			d.skip = 2'd2;
		end else if (b[7:3] == 5'b11110) begin
			d.skip = 2'd3;
		end
		return d;
	endfunction

endpackage

`default_nettype wire

// File: rtl/utf8_to_latin1_stream_core.sv
// UTF-8 to ISO-8859-1 stream transcoder, top level.
// Depends on u2l_pkg and utf8_to_latin1_stream_core_assert.svh.
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries one UTF-8 byte per beat
//   plus a last flag for the final byte of a string. Output channel
//   out_valid/out_ready/out_data carries one Latin-1 byte per beat, with
//   run_final on the last beat caused by an input byte and string_end when
//   that byte carried the last flag. An input byte causes zero, one or two
//   output beats.
//   cfg_we/cfg_data write the replacement byte (reset value '?'); write it
//   only while the block is idle.
//   An input beat reaches its first output beat through one input register,
//   then decode into a two-entry result queue.
//   Throughput is one input byte per cycle; a byte with two beats stalls the
//   input only when the queue still holds a beat after the pop.
//   When the receiver stalls, the queue fills and in_ready drops once the
//   input register cannot drain; nothing is lost.
//   Reset clears the decoder state, the queue and the input register, and
//   restores the replacement byte.
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_to_latin1_stream_core_assert.svh"

module utf8_to_latin1_stream_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire u2l_pkg::in_beat_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output u2l_pkg::out_beat_t      out_data,
	input  wire logic               cfg_we,
	input  wire logic [7:0]         cfg_data
);

	logic               valid_s1;
	u2l_pkg::in_beat_t  beat_s1;
	logic [7:0]         repl_q;
	logic               lead_pending_q;
	logic               lead_c3_q;
	logic [1:0]         skip_q;
	u2l_pkg::out_beat_t fifo0_q, fifo1_q;
	logic [1:0]         cnt_q;

	logic               s1_fire, pop, fits;
	logic [1:0]         n_res;
	u2l_pkg::out_beat_t r0, r1;
	logic               lead_nxt, c3_nxt;
	logic [1:0]         skip_nxt;
	u2l_pkg::dec_t      dec;
	logic [1:0]         ac;
	u2l_pkg::out_beat_t a0, a1, nxt0, nxt1;
	logic [2:0]         fill;

	// Hold replacement byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repl_q <= u2l_pkg::REPL_RESET;
		end else if (cfg_we) begin
			repl_q <= cfg_data;
		end
	end

	// Input register: load when empty or draining
	assign in_ready = !valid_s1 || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			beat_s1 <= in_data;
		end
	end

	// Decode the registered byte against the sequence state
	always_comb begin
		logic [7:0] b;
		logic       last;
		b        = beat_s1.in_byte;
		last     = beat_s1.in_last;
		dec      = u2l_pkg::decode(b, last, repl_q);
		n_res    = 2'd0;
		r0       = '{out_byte: repl_q, run_final: 1'b1, string_end: last};
		r1       = '{out_byte: dec.data, run_final: 1'b1, string_end: last};
		lead_nxt = dec.lead;
		c3_nxt   = dec.c3;
		skip_nxt = dec.skip;
		if (lead_pending_q) begin
			if (u2l_pkg::is_cont(b)) begin
				n_res       = 2'd1;
				r0.out_byte = {1'b1, lead_c3_q, b[5:0]};
				lead_nxt    = 1'b0;
				c3_nxt      = lead_c3_q;
				skip_nxt    = 2'd0;
			end else if (dec.emit) begin
				// replacement for the orphan lead, then the new byte
				n_res        = 2'd2;
				r0.run_final = 1'b0;
			end else begin
				n_res = 2'd1;
			end
		end else if (skip_q != 2'd0 && u2l_pkg::is_cont(b)) begin
			// swallow continuation byte
			n_res    = 2'd0;
			lead_nxt = 1'b0;
			c3_nxt   = lead_c3_q;
			skip_nxt = skip_q - 2'd1;
		end else begin
			n_res       = {1'b0, dec.emit};
			r0.out_byte = dec.data;
		end
		if (last) begin
			lead_nxt = 1'b0;
			c3_nxt   = 1'b0;
			skip_nxt = 2'd0;
		end
	end

	// Advance decoder state on each consumed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_pending_q <= 1'b0;
			lead_c3_q      <= 1'b0;
			skip_q         <= 2'd0;
		end else if (s1_fire) begin
			lead_pending_q <= lead_nxt;
			lead_c3_q      <= c3_nxt;
			skip_q         <= skip_nxt;
		end
	end

	// Result queue: pop head, then append this byte's results if they fit
	assign out_valid = cnt_q != 2'd0;
	assign out_data  = fifo0_q;
	assign pop       = out_valid && out_ready;

	always_comb begin
		if (pop) begin
			a0 = fifo1_q;
			a1 = fifo1_q;
			ac = cnt_q - 2'd1;
		end else begin
			a0 = fifo0_q;
			a1 = fifo1_q;
			ac = cnt_q;
		end
		fill    = {1'b0, ac} + {1'b0, n_res};
		fits    = fill <= 3'd2;
		s1_fire = valid_s1 && fits;
		nxt0    = a0;
		nxt1    = a1;
		if (s1_fire) begin
			case (ac)
				2'd0: begin
					nxt0 = r0;
					nxt1 = r1;
				end
				2'd1: begin
					nxt1 = r0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= s1_fire ? fill[1:0] : ac;
		end
	end

	always_ff @(posedge clk) begin
		fifo0_q <= nxt0;
		fifo1_q <= nxt1;
	end

	// Checks
	`U2L_ASSERT_ALWAYS(a_cnt_range, cnt_q <= 2'd2)
	`U2L_ASSERT_ALWAYS(a_lead_skip_excl, !(lead_pending_q && skip_q != 2'd0))
	`U2L_ASSERT_ALWAYS(a_pair_held, !(out_valid && !out_data.run_final) || cnt_q == 2'd2)
	`U2L_ASSERT_NEXT(a_last_clears, s1_fire && beat_s1.in_last, !lead_pending_q && skip_q == 2'd0)

endmodule

`default_nettype wire
